// ===== design/assert_macros.svh =====
// Assertion shorthands shared by the design files.
// Each expects clk and rst_n in the scope of the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check.
`define SESF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sesf: same-cycle check failed");

// Next-cycle implication check.
`define SESF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sesf: next-cycle check failed");

`endif

// ===== design/sesf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sesf_pkg;

    // Field widths of the channel words
    localparam int X_W = 9;
    localparam int Y_W = 6;

    // Defaults for the top-level parameters
    localparam int ROWS_DEF            = 64;
    localparam int SLOPE_FRAC_BITS_DEF = 16;

    // Columns on the screen; crossings saturate to COLS-1
    localparam int COLS = 512;

    // Action codes
    localparam logic ACT_BEGIN = 1'b0;
    localparam logic ACT_EDGE  = 1'b1;

    typedef struct packed {
        logic           action;
        logic [X_W-1:0] x_start;
        logic [Y_W-1:0] y_start;
        logic [X_W-1:0] x_end;
        logic [Y_W-1:0] y_end;
    } in_word_t;

    typedef struct packed {
        logic [Y_W-1:0] row;
        logic [X_W-1:0] span_first;
        logic [X_W-1:0] span_last;
        logic           span_valid;
        logic           last;
    } out_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_DIV,
        S_READ,
        S_UPDATE,
        S_FLUSH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic rd;
        logic upd;
        logic fin;
    } sesf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_begin;
        logic flat;
        logic div_last;
        logic last_row;
        logic blocked;
        logic out_free;
    } sesf_status_t;

endpackage

`default_nettype wire

// ===== design/sesf_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sesf_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/sesf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sesf_ctrl import sesf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  sesf_status_t status,
    output sesf_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   last_step;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.is_begin || status.flat)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (!status.blocked)
                begin
                    state_next = status.last_row ? S_FLUSH : S_READ;
                end
            end
            S_FLUSH:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_DISPATCH:
            begin
                cmd = '0;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_READ:
            begin
                cmd.rd = 1'b1;
            end
            S_UPDATE:
            begin
                cmd.upd = !status.blocked;
            end
            S_FLUSH:
            begin
                cmd.fin = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Final row step of the walk
    assign last_step = (state_reg == S_UPDATE) && !status.blocked && status.last_row;

    `SESF_ASSERT_IMP(a_upd_unblocked, cmd.upd, !status.blocked)
    `SESF_ASSERT_NXT(a_last_row_flush, last_step, state_reg == S_FLUSH)

endmodule

`default_nettype wire

// ===== design/sesf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sesf_datapath import sesf_pkg::*;
#(
    parameter int ROWS            = ROWS_DEF,
    parameter int SLOPE_FRAC_BITS = SLOPE_FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  sesf_cmd_t    cmd,
    output sesf_status_t status,
    input  in_word_t     in_word,
    output logic         out_valid,
    input  logic         out_ready,
    output out_word_t    out_word
);

    localparam int ACC_W = X_W + SLOPE_FRAC_BITS;
    localparam int RW    = $clog2(ROWS);
    localparam int CNT_W = $clog2(ACC_W);
    localparam int SP_W  = X_W + 2;
    localparam logic [X_W-1:0]         X_MAX  = X_W'(COLS - 1);
    localparam logic signed [SP_W-1:0] SP_ONE = SP_W'(1);

    // Edge registers
    logic                 action_reg;
    logic [Y_W-1:0]       y_hi_reg;
    logic [Y_W-1:0]       dy_reg;
    logic                 neg_reg;
    logic [Y_W-1:0]       row_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_W-1:0]     acc_next;

    // Divider registers: nq holds the dividend, then the quotient
    logic [ACC_W-1:0]     nq_reg;
    logic [ACC_W-1:0]     nq_next;
    logic [Y_W-1:0]       rem_reg;
    logic [Y_W-1:0]       rem_next;
    logic [CNT_W-1:0]     cnt_reg;

    // Row store
    logic [X_W-1:0]       left_mem  [ROWS];
    logic [X_W-1:0]       right_mem [ROWS];
    logic [X_W-1:0]       rd_left_reg;
    logic [X_W-1:0]       rd_right_reg;
    logic [ROWS-1:0]      occ_reg;

    // Held span and output register
    logic                 pend_valid_reg;
    out_word_t            pend_reg;
    logic                 out_valid_reg;
    out_word_t            out_reg;
    out_word_t            out_next;

    // Ordering of the incoming endpoints
    logic                 swap;
    logic [X_W-1:0]       x_lo_in;
    logic [X_W-1:0]       x_hi_in;
    logic [Y_W-1:0]       y_lo_in;
    logic [Y_W-1:0]       y_hi_in;
    logic                 neg_in;
    logic [X_W-1:0]       mag_in;

    // Row update
    logic [RW-1:0]        row_idx;
    logic                 in_range;
    logic                 occ;
    logic [X_W-1:0]       cx_raw;
    logic [X_W-1:0]       cx;
    logic                 lt;
    logic                 gt;
    logic                 close;
    logic signed [SP_W-1:0] sp_first;
    logic signed [SP_W-1:0] sp_last;
    logic                 emit;
    logic                 out_free;
    logic                 out_push;

    // Divider step
    logic [Y_W:0]         trial;
    logic [Y_W:0]         diff;
    logic                 ge;
    logic [ACC_W-1:0]     step;

    // Order endpoints by y and take the magnitude of dx
    always_comb
    begin
        swap    = in_word.y_end < in_word.y_start;
        x_lo_in = swap ? in_word.x_end   : in_word.x_start;
        x_hi_in = swap ? in_word.x_start : in_word.x_end;
        y_lo_in = swap ? in_word.y_end   : in_word.y_start;
        y_hi_in = swap ? in_word.y_start : in_word.y_end;
        neg_in  = x_hi_in < x_lo_in;
        mag_in  = neg_in ? (x_lo_in - x_hi_in) : (x_hi_in - x_lo_in);
    end

    // One restoring division bit per step
    always_comb
    begin
        trial    = {rem_reg, nq_reg[ACC_W-1]};
        ge       = trial >= {1'b0, dy_reg};
        diff     = trial - {1'b0, dy_reg};
        rem_next = ge ? diff[Y_W-1:0] : trial[Y_W-1:0];
        nq_next  = {nq_reg[ACC_W-2:0], ge};
    end

    // Advance x by the signed slope
    always_comb
    begin
        step     = neg_reg ? (~nq_reg + ACC_W'(1)) : nq_reg;
        acc_next = acc_reg + step;
    end

    // Compare the crossing with the stored pair
    always_comb
    begin
        row_idx  = RW'(row_reg);
        in_range = 32'(row_reg) < ROWS;
        occ      = occ_reg[row_idx];
        cx_raw   = acc_reg[ACC_W-1 -: X_W];
        cx       = (32'(cx_raw) > COLS - 1) ? X_MAX : cx_raw;
        lt       = acc_reg < {rd_left_reg, {SLOPE_FRAC_BITS{1'b0}}};
        gt       = acc_reg > {rd_right_reg, {SLOPE_FRAC_BITS{1'b0}}};
        if (lt)
        begin
            sp_first = $signed({2'b00, cx}) + SP_ONE;
            sp_last  = $signed({2'b00, rd_right_reg}) - SP_ONE;
        end
        else
        begin
            sp_first = $signed({2'b00, rd_left_reg}) + SP_ONE;
            sp_last  = $signed({2'b00, cx}) - SP_ONE;
        end
        close    = occ && (lt || gt);
        emit     = in_range && close && (sp_first <= sp_last);
        out_free = !out_valid_reg || out_ready;
        out_push = (cmd.upd && emit && pend_valid_reg) || cmd.fin;
    end

    // Select the word for the output register
    always_comb
    begin
        if (cmd.fin)
        begin
            out_next = pend_valid_reg ? pend_reg : '0;
            out_next.last = 1'b1;
        end
        else
        begin
            out_next = pend_reg;
            out_next.last = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                pend_valid_reg <= 1'b0;
                cnt_reg        <= '0;
                if (in_word.action == ACT_BEGIN)
                begin
                    occ_reg <= '0;
                end
            end
            if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.upd && in_range)
            begin
                if (!occ)
                begin
                    occ_reg[row_idx] <= 1'b1;
                end
                else if (close)
                begin
                    occ_reg[row_idx] <= 1'b0;
                end
                if (emit)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
            if (out_push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Edge, divider and span payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= in_word.action;
            y_hi_reg   <= y_hi_in;
            dy_reg     <= y_hi_in - y_lo_in;
            neg_reg    <= neg_in;
            row_reg    <= y_lo_in;
            acc_reg    <= {x_lo_in, {SLOPE_FRAC_BITS{1'b0}}};
            nq_reg     <= {mag_in, {SLOPE_FRAC_BITS{1'b0}}};
            rem_reg    <= '0;
        end
        if (cmd.div_step)
        begin
            nq_reg  <= nq_next;
            rem_reg <= rem_next;
        end
        if (cmd.upd)
        begin
            acc_reg <= acc_next;
            row_reg <= row_reg + Y_W'(1);
            if (emit)
            begin
                pend_reg.row        <= row_reg;
                pend_reg.span_first <= sp_first[X_W-1:0];
                pend_reg.span_last  <= sp_last[X_W-1:0];
                pend_reg.span_valid <= 1'b1;
                pend_reg.last       <= 1'b0;
            end
        end
        if (out_push)
        begin
            out_reg <= out_next;
        end
    end

    // Crossing store: write on the first crossing, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.upd && in_range && !occ)
        begin
            left_mem[row_idx]  <= cx;
            right_mem[row_idx] <= cx;
        end
        if (cmd.rd)
        begin
            rd_left_reg  <= left_mem[row_idx];
            rd_right_reg <= right_mem[row_idx];
        end
    end

    // Status to the controller
    always_comb
    begin
        status.is_begin = action_reg == ACT_BEGIN;
        status.flat     = dy_reg == '0;
        status.div_last = cnt_reg == CNT_W'(ACC_W - 1);
        status.last_row = ({1'b0, row_reg} + (Y_W + 1)'(1)) == {1'b0, y_hi_reg};
        status.blocked  = emit && pend_valid_reg && !out_free;
        status.out_free = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    `SESF_ASSERT_IMP(a_push_free, out_push, out_free)
    `SESF_ASSERT_NXT(a_fin_last, cmd.fin, out_valid_reg && out_reg.last)

endmodule

`default_nettype wire

// ===== design/scanline_edge_span_fill.sv =====
// Scanline span fill, one polygon edge per input word.
// Input channel "edges" carries action, x_start, y_start, x_end, y_end.
// Action begin clears every row; action edge walks the rows the edge covers.
// Output channel "spans" carries row, span_first, span_last, span_valid, last.
// Every input word gives one or more output words; the final one has last set.
// An edge that closes no non-empty span, and every begin, give a single word
// with span_valid low.
// Sequence: after the load and dispatch steps, an edge gets its slope from a
// one-bit-per-cycle divider, then each row takes a crossing-store read
// followed by a compare and write. A begin or a flat edge skips the divider
// and the row walk and goes straight to its final word.
// One word is taken at a time; edges.ready is high only when the block is idle.
// Reset clears all row-occupied flags and empties the output register.
// When spans stalls, the walk pauses on the next span to emit, and the final
// word waits in the output register until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module scanline_edge_span_fill import sesf_pkg::*;
#(
    parameter int ROWS            = ROWS_DEF,
    parameter int SLOPE_FRAC_BITS = SLOPE_FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    sesf_stream_if.sink   edges,
    sesf_stream_if.source spans
);

    sesf_cmd_t    cmd;
    sesf_status_t status;
    logic         in_ready;
    logic         out_valid;
    out_word_t    out_word;

    // Sequencer
    sesf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (edges.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Divider, row walker, crossing store and output register
    sesf_datapath #(
        .ROWS            (ROWS),
        .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_word   (edges.data),
        .out_valid (out_valid),
        .out_ready (spans.ready),
        .out_word  (out_word)
    );

    assign edges.ready = in_ready;
    assign spans.valid = out_valid;
    assign spans.data  = out_word;

endmodule

`default_nettype wire

// ===== tb/scanline_edge_span_fill_test.sv =====
`timescale 1ns / 1ps

module scanline_edge_span_fill_test import sesf_pkg::*;
();

    localparam int FRAC      = SLOPE_FRAC_BITS_DEF;
    localparam int NROWS     = ROWS_DEF;
    localparam int LIMIT     = 2_000_000;
    localparam int TAIL      = 200;

    typedef struct {
        in_word_t w;
        bit       drain;
    } pending_t;

    logic clk;
    logic rst_n;

    sesf_stream_if #(.word_t(in_word_t))  edges_if ();
    sesf_stream_if #(.word_t(out_word_t)) spans_if ();

    scanline_edge_span_fill uut (
        .clk   (clk),
        .rst_n (rst_n),
        .edges (edges_if.sink),
        .spans (spans_if.source)
    );

    // Crossing store of the predicted fill
    logic [X_W-1:0] row_left  [NROWS];
    logic [X_W-1:0] row_right [NROWS];
    bit             row_busy  [NROWS];

    pending_t  edge_backlog   [$];
    out_word_t expected_spans [$];

    int mismatches;
    int begins_sent;
    int edges_sent;
    int words_seen;
    int spans_seen;
    int cycles;

    // Sender burst state and receiver stall state
    int burst_left;
    int gap_left;
    int stall_mode;
    int stall_window;
    int stall_hold;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Walk one word through the fill and queue the words it should produce
    function automatic void trace_word(input in_word_t w);
        longint    xa, ya, xb, yb, t, dy, slope, acc, cx, lc, rc, span_lo, span_hi;
        int        r;
        int        n;
        bit        shut;
        out_word_t o;
        out_word_t found [$];
        n = 0;
        if (w.action == ACT_BEGIN)
        begin
            foreach (row_busy[i])
                row_busy[i] = 1'b0;
        end
        else
        begin
            xa = w.x_start;
            ya = w.y_start;
            xb = w.x_end;
            yb = w.y_end;
            if (yb < ya)
            begin
                t = xa; xa = xb; xb = t;
                t = ya; ya = yb; yb = t;
            end
            if (yb > ya)
            begin
                dy    = yb - ya;
                slope = ((xb - xa) <<< FRAC) / dy;
                acc   = xa <<< FRAC;
                for (r = int'(ya); r < int'(yb); r++)
                begin
                    if (r < NROWS)
                    begin
                        cx = acc >>> FRAC;
                        if (cx > COLS - 1)
                            cx = COLS - 1;
                        if (!row_busy[r])
                        begin
                            row_left[r]  = X_W'(cx);
                            row_right[r] = X_W'(cx);
                            row_busy[r]  = 1'b1;
                        end
                        else
                        begin
                            lc   = row_left[r];
                            rc   = row_right[r];
                            shut = 1'b0;
                            if (acc < (lc <<< FRAC))
                            begin
                                span_lo = cx + 1;
                                span_hi = rc - 1;
                                shut    = 1'b1;
                            end
                            else if (acc > (rc <<< FRAC))
                            begin
                                span_lo = lc + 1;
                                span_hi = cx - 1;
                                shut    = 1'b1;
                            end
                            if (shut)
                            begin
                                if (span_lo <= span_hi && n < 64)
                                begin
                                    o            = '0;
                                    o.row        = Y_W'(r);
                                    o.span_first = X_W'(span_lo);
                                    o.span_last  = X_W'(span_hi);
                                    o.span_valid = 1'b1;
                                    found.push_back(o);
                                    n++;
                                end
                                row_busy[r] = 1'b0;
                            end
                        end
                    end
                    acc += slope;
                end
            end
        end
        // No non-empty span closed: a single empty word
        if (n == 0)
        begin
            o = '0;
            found.push_back(o);
        end
        found[found.size() - 1].last = 1'b1;
        foreach (found[i])
            expected_spans.push_back(found[i]);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void queue_word(logic act, int xs, int ys, int xe, int ye, bit drain);
        pending_t p;
        p.w.action  = act;
        p.w.x_start = X_W'(xs);
        p.w.y_start = Y_W'(ys);
        p.w.x_end   = X_W'(xe);
        p.w.y_end   = Y_W'(ye);
        p.drain     = drain;
        edge_backlog.push_back(p);
    endfunction

    // Fill the backlog: directed words first, then random polygons and stray edges
    initial
    begin : build_stimulus
        int vx [8];
        int vy [8];
        int nv;
        int ext;
        int ylo;
        int produced;
        int skip;
        int pick;

        // Flat edge, full-height columns at both extremes
        queue_word(ACT_BEGIN, 0, 0, 0, 0, 1'b1);
        queue_word(ACT_EDGE, 100, 20, 300, 20, 1'b0);
        queue_word(ACT_EDGE, 0, 0, 0, 63, 1'b0);
        queue_word(ACT_EDGE, 511, 63, 511, 0, 1'b0);
        // Adjacent crossings close rows with nothing between them
        queue_word(ACT_BEGIN, 0, 0, 0, 0, 1'b0);
        queue_word(ACT_EDGE, 10, 5, 10, 9, 1'b0);
        queue_word(ACT_EDGE, 11, 9, 11, 5, 1'b0);
        // Repeat crossing, then a slanted edge across the open rows
        queue_word(ACT_EDGE, 50, 5, 50, 9, 1'b0);
        queue_word(ACT_EDGE, 50, 5, 50, 9, 1'b0);
        queue_word(ACT_EDGE, 40, 5, 60, 9, 1'b0);
        // Triangle with a flat bottom
        queue_word(ACT_BEGIN, 0, 0, 0, 0, 1'b0);
        queue_word(ACT_EDGE, 100, 10, 200, 40, 1'b0);
        queue_word(ACT_EDGE, 200, 40, 20, 40, 1'b0);
        queue_word(ACT_EDGE, 20, 40, 100, 10, 1'b0);
        // Crossing diagonals of opposite slope, then one landing between crossings
        queue_word(ACT_BEGIN, 0, 0, 0, 0, 1'b0);
        queue_word(ACT_EDGE, 511, 0, 0, 63, 1'b0);
        queue_word(ACT_EDGE, 0, 0, 511, 63, 1'b0);
        queue_word(ACT_EDGE, 300, 0, 200, 20, 1'b0);
        // Half-pixel slope: compare on the fractional x
        queue_word(ACT_BEGIN, 0, 0, 0, 0, 1'b0);
        queue_word(ACT_EDGE, 5, 0, 6, 2, 1'b0);
        queue_word(ACT_EDGE, 5, 0, 5, 2, 1'b0);
        queue_word(ACT_EDGE, 6, 1, 6, 2, 1'b0);
        queue_word(ACT_EDGE, 4, 2, 4, 0, 1'b0);

        produced = 0;
        while (produced < 350)
        begin
            // Noise: a stray edge between polygons
            if ($urandom_range(0, 5) == 0)
            begin
                queue_word(ACT_EDGE, $urandom_range(0, 511), $urandom_range(0, 63),
                           $urandom_range(0, 511), $urandom_range(0, 63), 1'b0);
                produced++;
            end
            // Most polygons start with a begin; some hold off until drained
            if ($urandom_range(0, 9) != 0)
            begin
                queue_word(ACT_BEGIN, $urandom_range(0, 511), $urandom_range(0, 63),
                           $urandom_range(0, 511), $urandom_range(0, 63),
                           $urandom_range(0, 7) == 0);
                produced++;
            end
            nv  = $urandom_range(3, 6);
            ext = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 12);
            ylo = $urandom_range(0, 63 - ext);
            for (int i = 0; i < nv; i++)
            begin
                pick  = $urandom_range(0, 3);
                vx[i] = (pick == 0) ? 0 : (pick == 1) ? 511 : $urandom_range(0, 511);
                vx[i] = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 511) : vx[i];
                vy[i] = $urandom_range(ylo, ylo + ext);
            end
            // Broken polygons drop one edge
            skip = ($urandom_range(0, 9) == 0) ? $urandom_range(0, nv - 1) : -1;
            for (int i = 0; i < nv; i++)
            begin
                if (i != skip)
                begin
                    if ($urandom_range(0, 1) == 0)
                        queue_word(ACT_EDGE, vx[i], vy[i], vx[(i + 1) % nv],
                                   vy[(i + 1) % nv], 1'b0);
                    else
                        queue_word(ACT_EDGE, vx[(i + 1) % nv], vy[(i + 1) % nv],
                                   vx[i], vy[i], 1'b0);
                    produced++;
                end
            end
        end
    end

    // Drive edge words in bursts; hold a draining word until all spans are back
    always @(posedge clk or negedge rst_n)
    begin : drive_edges
        logic     go;
        pending_t nxt;
        if (!rst_n)
        begin
            edges_if.valid <= 1'b0;
            edges_if.data  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            go = edges_if.valid;
            if (edges_if.valid && edges_if.ready)
            begin
                trace_word(edges_if.data);
                if (edges_if.data.action == ACT_BEGIN)
                    begins_sent++;
                else
                    edges_sent++;
                go = 1'b0;
            end
            if (!go)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (edge_backlog.size() != 0 &&
                         !(edge_backlog[0].drain && expected_spans.size() != 0))
                begin
                    nxt = edge_backlog.pop_front();
                    edges_if.data <= nxt.w;
                    go = 1'b1;
                    if (burst_left <= 1)
                    begin
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                        burst_left = $urandom_range(1, 12);
                    end
                    else
                        burst_left--;
                end
            end
            edges_if.valid <= go;
        end
    end

    // Check span words and stall the receiver in windows of changing behavior
    always @(posedge clk or negedge rst_n)
    begin : watch_spans
        out_word_t want;
        logic      rdy;
        if (!rst_n)
        begin
            spans_if.ready <= 1'b0;
            stall_mode   = 0;
            stall_window = 0;
            stall_hold   = 0;
        end
        else
        begin
            if (spans_if.valid && spans_if.ready)
            begin
                words_seen++;
                if (spans_if.data.span_valid)
                    spans_seen++;
                if (expected_spans.size() == 0)
                begin
                    $error("span word with none expected: row %0d first %0d last %0d",
                           spans_if.data.row, spans_if.data.span_first,
                           spans_if.data.span_last);
                    mismatches++;
                end
                else
                begin
                    want = expected_spans.pop_front();
                    check_field("row", want.row, spans_if.data.row);
                    check_field("span_first", want.span_first, spans_if.data.span_first);
                    check_field("span_last", want.span_last, spans_if.data.span_last);
                    check_field("span_valid", want.span_valid, spans_if.data.span_valid);
                    check_field("last", want.last, spans_if.data.last);
                end
            end
            if (stall_window == 0)
            begin
                stall_mode   = $urandom_range(0, 2);
                stall_window = $urandom_range(20, 200);
            end
            stall_window--;
            case (stall_mode)
                0: rdy = 1'b1;
                1: rdy = $urandom_range(0, 1);
                default:
                begin
                    if (stall_hold > 0)
                    begin
                        stall_hold--;
                        rdy = 1'b0;
                    end
                    else
                    begin
                        rdy = 1'b1;
                        if ($urandom_range(0, 3) == 0)
                            stall_hold = $urandom_range(1, 12);
                    end
                end
            endcase
            spans_if.ready <= rdy;
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles, %0d span words outstanding",
                     cycles, expected_spans.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Reset, then wait for the backlog and the expected spans to drain
    initial
    begin
        mismatches     = 0;
        begins_sent    = 0;
        edges_sent     = 0;
        words_seen     = 0;
        spans_seen     = 0;
        cycles         = 0;
        rst_n          = 1'b0;
        edges_if.valid = 1'b0;
        edges_if.data  = '0;
        spans_if.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (edge_backlog.size() != 0 || edges_if.valid || expected_spans.size() != 0)
            @(negedge clk);
        repeat (TAIL) @(posedge clk);
        if (expected_spans.size() != 0)
        begin
            $error("%0d span words never arrived", expected_spans.size());
            mismatches++;
        end
        $display("Sent %0d begin and %0d edge words; checked %0d span words, %0d of them",
                 begins_sent, edges_sent, words_seen, spans_seen);
        $display("non-empty spans, with random burst gaps and receiver stalls.");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== scanline_edge_span_fill.f =====
+incdir+design
design/sesf_pkg.sv
design/sesf_stream_if.sv
design/sesf_ctrl.sv
design/sesf_datapath.sv
design/scanline_edge_span_fill.sv
tb/scanline_edge_span_fill_test.sv
